### rtl/lbbc_pkg.sv
// shared constants, codes and types of the lru block buffer cache
`default_nettype none
package lbbc_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_IN_W  = 5;
    localparam int DEV_W      = 8;
    localparam int BLK_W      = 32;
    localparam int CNT_W      = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_GET     = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_PIN     = 2'd2,
        REQ_UNPIN   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2,
        ST_OVER   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_GWRITE,
        S_SOP,
        S_RSWEEP,
        S_RFINAL,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

### rtl/lbbc_if.sv
// request and result channel interfaces of the lru block buffer cache
`default_nettype none
interface lbbc_req_if import lbbc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [DEV_W-1:0]     device;
    logic [BLK_W-1:0]     block_number;
    logic [SLOT_IN_W-1:0] slot_in;

    modport source (output valid, req_type, device, block_number, slot_in, input ready);
    modport sink   (input valid, req_type, device, block_number, slot_in, output ready);
endinterface

interface lbbc_res_if import lbbc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SLOT_IN_W-1:0] slot_out;
    logic                 hit;
    logic                 need_read;
    logic [1:0]           status;

    modport source (output valid, slot_out, hit, need_read, status, input ready);
    modport sink   (input valid, slot_out, hit, need_read, status, output ready);
endinterface
`default_nettype wire

### rtl/lru_block_buffer_cache_unit.sv
// top level of the lru block buffer cache with per-slot reference counts
`default_nettype none
// Buffer cache of NUM_SLOTS slots, each with a device tag, a block tag, a
// valid bit, an 8-bit reference count and a recency rank (highest = newest).
// A get walks every slot once, one slot per clock, through a single
// tag/count/rank compare unit fed from the slot memories; it then grants the
// newest matching slot (hit) or recycles the oldest slot with count zero.
// Release, pin and unpin read the addressed slot and adjust its count; a
// release that drops the count to zero walks all ranks once more to move
// the slot to the newest place. The next item is taken only once the
// previous one has finished its walk and its response step. After reset
// a clearing pass loads the reset tags and ranks and no item is taken
// meanwhile. A finished result sits in an output register, so the next
// item is taken even while the previous result waits; the response step
// stalls only if the output register is still full then.
module lru_block_buffer_cache_unit
    import lbbc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lbbc_req_if.sink    i_req,
    lbbc_res_if.source  o_res
);

    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(NUM_SLOTS - 1);

    // slot memories, one write and one registered read port each
    logic [DEV_W-1:0]  mem_dev  [NUM_SLOTS];
    logic [BLK_W-1:0]  mem_blk  [NUM_SLOTS];
    logic              mem_vld  [NUM_SLOTS];
    logic [CNT_W-1:0]  mem_cnt  [NUM_SLOTS];
    logic [SLOT_W-1:0] mem_rank [NUM_SLOTS];

    // read data of the slot addressed in the previous cycle
    logic [DEV_W-1:0]  r_rd_dev;
    logic [BLK_W-1:0]  r_rd_blk;
    logic              r_rd_vld;
    logic [CNT_W-1:0]  r_rd_cnt;
    logic [SLOT_W-1:0] r_rd_rank;

    // memory control
    logic [SLOT_W-1:0] w_raddr;
    logic [SLOT_W-1:0] w_waddr;
    logic              w_we_tag, w_we_vld, w_we_cnt, w_we_rank;
    logic [DEV_W-1:0]  w_wdev;
    logic [BLK_W-1:0]  w_wblk;
    logic              w_wvld;
    logic [CNT_W-1:0]  w_wcnt;
    logic [SLOT_W-1:0] w_wrank;

    // sequencer state
    t_state               r_state,    n_state;
    logic [SLOT_W-1:0]    r_idx,      n_idx;
    t_req                 r_req,      n_req;
    logic [DEV_W-1:0]     r_dev,      n_dev;
    logic [BLK_W-1:0]     r_blk,      n_blk;
    logic [SLOT_IN_W-1:0] r_slot_in,  n_slot_in;

    // best matching slot so far (newest) and best free slot so far (oldest)
    logic                 r_found,    n_found;
    logic [SLOT_W-1:0]    r_hit_idx,  n_hit_idx;
    logic [SLOT_W-1:0]    r_hit_rank, n_hit_rank;
    logic [CNT_W-1:0]     r_hit_cnt,  n_hit_cnt;
    logic                 r_hit_vld,  n_hit_vld;
    logic                 r_got,      n_got;
    logic [SLOT_W-1:0]    r_free_idx, n_free_idx;
    logic [SLOT_W-1:0]    r_free_rank, n_free_rank;
    logic [SLOT_W-1:0]    r_ref_rank, n_ref_rank;

    // result being built and output register
    logic [SLOT_IN_W-1:0] r_res_slot, n_res_slot;
    logic                 r_res_hit,  n_res_hit;
    logic                 r_res_nr,   n_res_nr;
    t_status              r_res_st,   n_res_st;
    logic                 r_out_valid, n_out_valid;
    logic [SLOT_IN_W-1:0] r_out_slot, n_out_slot;
    logic                 r_out_hit,  n_out_hit;
    logic                 r_out_nr,   n_out_nr;
    t_status              r_out_st,   n_out_st;

    logic [SLOT_W-1:0]    w_next_idx;
    logic [SLOT_W-1:0]    w_slot;
    logic                 w_slot_bad;
    logic                 w_match;
    logic                 w_accept;

    assign w_next_idx = (r_idx == LAST) ? '0 : r_idx + 1'b1;
    assign w_slot     = SLOT_W'(r_slot_in);
    assign w_slot_bad = 32'(i_req.slot_in) >= 32'(NUM_SLOTS);
    assign w_match    = (r_rd_dev == r_dev) && (r_rd_blk == r_blk);

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.slot_out  = r_out_slot;
    assign o_res.hit       = r_out_hit;
    assign o_res.need_read = r_out_nr;
    assign o_res.status    = r_out_st;

    // slot memories
    always_ff @(posedge i_clk) begin
        if (w_we_tag) begin
            mem_dev[w_waddr] <= w_wdev;
            mem_blk[w_waddr] <= w_wblk;
        end
        if (w_we_vld) begin
            mem_vld[w_waddr] <= w_wvld;
        end
        if (w_we_cnt) begin
            mem_cnt[w_waddr] <= w_wcnt;
        end
        if (w_we_rank) begin
            mem_rank[w_waddr] <= w_wrank;
        end
        r_rd_dev  <= mem_dev[w_raddr];
        r_rd_blk  <= mem_blk[w_raddr];
        r_rd_vld  <= mem_vld[w_raddr];
        r_rd_cnt  <= mem_cnt[w_raddr];
        r_rd_rank <= mem_rank[w_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_dev       <= n_dev;
        r_blk       <= n_blk;
        r_slot_in   <= n_slot_in;
        r_found     <= n_found;
        r_hit_idx   <= n_hit_idx;
        r_hit_rank  <= n_hit_rank;
        r_hit_cnt   <= n_hit_cnt;
        r_hit_vld   <= n_hit_vld;
        r_got       <= n_got;
        r_free_idx  <= n_free_idx;
        r_free_rank <= n_free_rank;
        r_ref_rank  <= n_ref_rank;
        r_res_slot  <= n_res_slot;
        r_res_hit   <= n_res_hit;
        r_res_nr    <= n_res_nr;
        r_res_st    <= n_res_st;
        r_out_slot  <= n_out_slot;
        r_out_hit   <= n_out_hit;
        r_out_nr    <= n_out_nr;
        r_out_st    <= n_out_st;
    end

    // sequencer: next state, memory control and result
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_req       = r_req;
        n_dev       = r_dev;
        n_blk       = r_blk;
        n_slot_in   = r_slot_in;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_hit_rank  = r_hit_rank;
        n_hit_cnt   = r_hit_cnt;
        n_hit_vld   = r_hit_vld;
        n_got       = r_got;
        n_free_idx  = r_free_idx;
        n_free_rank = r_free_rank;
        n_ref_rank  = r_ref_rank;
        n_res_slot  = r_res_slot;
        n_res_hit   = r_res_hit;
        n_res_nr    = r_res_nr;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_slot  = r_out_slot;
        n_out_hit   = r_out_hit;
        n_out_nr    = r_out_nr;
        n_out_st    = r_out_st;

        w_raddr   = w_next_idx;
        w_waddr   = r_idx;
        w_we_tag  = 1'b0;
        w_we_vld  = 1'b0;
        w_we_cnt  = 1'b0;
        w_we_rank = 1'b0;
        w_wdev    = r_dev;
        w_wblk    = r_blk;
        w_wvld    = 1'b1;
        w_wcnt    = r_rd_cnt;
        w_wrank   = r_rd_rank;

        unique case (r_state)
            S_CLEAR: begin
                // reset tags, counts and valid bits, rank equal to slot index
                w_waddr   = r_idx;
                w_we_tag  = 1'b1;
                w_we_vld  = 1'b1;
                w_we_cnt  = 1'b1;
                w_we_rank = 1'b1;
                w_wdev    = '0;
                w_wblk    = '0;
                w_wvld    = 1'b0;
                w_wcnt    = '0;
                w_wrank   = r_idx;
                n_idx     = w_next_idx;
                if (r_idx == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_req       = t_req'(i_req.req_type);
                n_dev       = i_req.device;
                n_blk       = i_req.block_number;
                n_slot_in   = i_req.slot_in;
                n_found     = 1'b0;
                n_got       = 1'b0;
                n_res_slot  = i_req.slot_in;
                n_res_hit   = 1'b0;
                n_res_nr    = 1'b0;
                n_res_st    = ST_OK;
                n_idx       = '0;
                w_raddr     = '0;
                if (w_accept) begin
                    if (t_req'(i_req.req_type) == REQ_GET) begin
                        n_state = S_SCAN;
                    end else if (w_slot_bad) begin
                        n_res_st = ST_NOFREE;
                        n_state  = S_RESP;
                    end else begin
                        w_raddr = SLOT_W'(i_req.slot_in);
                        n_state = S_SOP;
                    end
                end
            end
            S_SCAN: begin
                // one slot per cycle: newest tag match, oldest free slot
                if (w_match && (!r_found || r_rd_rank > r_hit_rank)) begin
                    n_found    = 1'b1;
                    n_hit_idx  = r_idx;
                    n_hit_rank = r_rd_rank;
                    n_hit_cnt  = r_rd_cnt;
                    n_hit_vld  = r_rd_vld;
                end
                if (r_rd_cnt == '0 && (!r_got || r_rd_rank < r_free_rank)) begin
                    n_got       = 1'b1;
                    n_free_idx  = r_idx;
                    n_free_rank = r_rd_rank;
                end
                n_idx = w_next_idx;
                if (r_idx == LAST) begin
                    n_state = S_GWRITE;
                end
            end
            S_GWRITE: begin
                n_state = S_RESP;
                if (r_found) begin
                    n_res_slot = SLOT_IN_W'(r_hit_idx);
                    n_res_hit  = 1'b1;
                    if (r_hit_cnt == CNT_MAX) begin
                        n_res_st = ST_OVER;
                    end else begin
                        w_waddr  = r_hit_idx;
                        w_we_cnt = 1'b1;
                        w_we_vld = 1'b1;
                        w_wcnt   = r_hit_cnt + 1'b1;
                        n_res_nr = !r_hit_vld;
                    end
                end else if (r_got) begin
                    // recycle the oldest idle slot
                    w_waddr    = r_free_idx;
                    w_we_tag   = 1'b1;
                    w_we_cnt   = 1'b1;
                    w_we_vld   = 1'b1;
                    w_wcnt     = CNT_W'(1);
                    n_res_slot = SLOT_IN_W'(r_free_idx);
                    n_res_nr   = 1'b1;
                end else begin
                    n_res_slot = '0;
                    n_res_st   = ST_NOFREE;
                end
            end
            S_SOP: begin
                w_waddr = w_slot;
                n_state = S_RESP;
                if (r_req == REQ_PIN) begin
                    if (r_rd_cnt == CNT_MAX) begin
                        n_res_st = ST_OVER;
                    end else begin
                        w_we_cnt = 1'b1;
                        w_wcnt   = r_rd_cnt + 1'b1;
                    end
                end else if (r_rd_cnt == '0) begin
                    n_res_st = ST_UNDER;
                end else begin
                    w_we_cnt = 1'b1;
                    w_wcnt   = r_rd_cnt - 1'b1;
                    if (r_req == REQ_RELEASE && r_rd_cnt == CNT_W'(1)) begin
                        // count drops to zero: move slot to newest place
                        n_ref_rank = r_rd_rank;
                        n_idx      = '0;
                        w_raddr    = '0;
                        n_state    = S_RSWEEP;
                    end
                end
            end
            S_RSWEEP: begin
                // every rank above the released one moves down by one
                w_waddr = r_idx;
                if (r_rd_rank > r_ref_rank) begin
                    w_we_rank = 1'b1;
                    w_wrank   = r_rd_rank - 1'b1;
                end
                n_idx = w_next_idx;
                if (r_idx == LAST) begin
                    n_state = S_RFINAL;
                end
            end
            S_RFINAL: begin
                w_waddr   = w_slot;
                w_we_rank = 1'b1;
                w_wrank   = LAST;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = r_res_slot;
                    n_out_hit   = r_res_hit;
                    n_out_nr    = r_res_nr;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // an accepted item always starts work before the next one is taken
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not leave idle");

    // the slot walk visits slots in order, one per cycle
    a_scan_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state == S_GWRITE || r_idx == $past(r_idx) + 1'b1))
        else $error("slot walk skipped a slot");

    // a hit only comes with success or a full count
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.hit) |-> (o_res.status == ST_OK || o_res.status == ST_OVER))
        else $error("hit with a bad status");

    // a disk read is only asked for on a successful get
    a_need_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.need_read) |-> (o_res.status == ST_OK))
        else $error("need_read on a failed request");
`endif

endmodule
`default_nettype wire
